// ===== hw/rtl/pce_pkg.sv =====
// shared types, constants and table sequencing for the permutation compose engine
package pce_pkg;

  localparam int PointW    = 8;
  localparam int MaxPoints = 1 << PointW;
  localparam int DegW      = $clog2(MaxPoints + 1);

  typedef logic [PointW-1:0] point_t;
  typedef logic [DegW-1:0]   deg_t;

  typedef enum logic [1:0] {
    CMD_WR_LEFT  = 2'd0,
    CMD_WR_RIGHT = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_PRODUCT   = 2'd0,
    OP_QUOTIENT  = 2'd1,
    OP_CONJUGATE = 2'd2,
    OP_UNUSED    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_OP_MODE      = 2'd0,
    CFG_LEFT_DEGREE  = 2'd1,
    CFG_RIGHT_DEGREE = 2'd2,
    CFG_NONE         = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_e;

  typedef enum logic [1:0] {
    SEL_LEFT,
    SEL_RIGHT,
    SEL_RINV
  } sel_e;

  // table read at a given lookup step
  function automatic sel_e table_sel(op_e mode, logic [1:0] step);
    sel_e sel;
    sel = SEL_LEFT;
    case (mode)
      OP_QUOTIENT:  sel = (step == 2'd0) ? SEL_LEFT : SEL_RINV;
      OP_CONJUGATE: begin
        case (step)
          2'd0:    sel = SEL_RINV;
          2'd1:    sel = SEL_LEFT;
          default: sel = SEL_RIGHT;
        endcase
      end
      default:      sel = (step == 2'd0) ? SEL_LEFT : SEL_RIGHT;
    endcase
    return sel;
  endfunction

  function automatic logic last_step(op_e mode, logic [1:0] step);
    return (mode == OP_CONJUGATE) ? (step == 2'd2) : (step == 2'd1);
  endfunction

endpackage

// ===== hw/rtl/pce_ram.sv =====
// table memory with one write port, per-lane write enables and registered read data
module pce_ram
  import pce_pkg::*;
#(
  parameter int Lanes = 1
) (
  input  logic                    clk_i,
  input  logic [Lanes-1:0]        we_i,
  input  point_t                  waddr_i,
  input  logic [Lanes*PointW-1:0] wdata_i,
  input  point_t                  raddr_i,
  output logic [Lanes*PointW-1:0] rdata_o
);

  logic [Lanes*PointW-1:0] mem [MaxPoints];
  logic [Lanes*PointW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Lanes; i++) begin
      if (we_i[i]) begin
        mem[waddr_i][i*PointW +: PointW] <= wdata_i[i*PointW +: PointW];
      end
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/permutation_compose_engine_unit.sv =====
// top level of the permutation compose engine: command decode, lookup sequencer, output register
//
// Writes (cmd 0 left entry, cmd 1 right entry with its inverse) are taken while busy stays
// low. A query is taken when start is high and busy low, then walks the tables one lookup per
// cycle through the registered read port of the table memories: two lookups for product,
// quotient and the unused mode, three for conjugate; busy is high during the lookups, and no
// new command is taken until it falls again. Each result appears on the result ports for exactly one
// cycle with result_valid_o high, the cycle after the last lookup; it must be captured then.
// Configuration may only be written while the block is idle.
module permutation_compose_engine_unit
  import pce_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   cmd_i,
  input  point_t       point_index_i,
  input  point_t       point_value_i,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  deg_t         cfg_data_i,
  output logic         result_valid_o,
  output point_t       queried_point_o,
  output point_t       image_o,
  output deg_t         result_degree_o
);

  state_e     state_q, state_d;
  logic [1:0] step_q, step_d;
  point_t     x_q, x_d;
  point_t     qpt_q;
  op_e        op_q;
  deg_t       ldeg_q, rdeg_q, lim_data;
  logic       valid_q, valid_d;
  point_t     image_q, image_d;
  point_t     raddr;
  logic [2*PointW-1:0] lr_rdata;
  point_t     l_rdata, r_rdata, ri_rdata, tbl_data, resolved;
  deg_t       tbl_deg;
  sel_e       sel;
  logic       accept, we_left, we_right;

  assign accept   = start && !busy;
  assign we_left  = accept && (cmd_i == CMD_WR_LEFT);
  assign we_right = accept && (cmd_i == CMD_WR_RIGHT);
  assign busy     = (state_q == ST_LOOK);

  // configuration
  assign lim_data = (cfg_data_i > deg_t'(MaxPoints)) ? deg_t'(MaxPoints) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= OP_PRODUCT;
      ldeg_q <= '0;
      rdeg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OP_MODE:      op_q   <= op_e'(cfg_data_i[1:0]);
        CFG_LEFT_DEGREE:  ldeg_q <= lim_data;
        CFG_RIGHT_DEGREE: rdeg_q <= lim_data;
        default: ;
      endcase
    end
  end

  // tables: left and right share one memory as two lanes, the inverse has its own
  pce_ram #(.Lanes(2)) u_lr (
    .clk_i   (clk_i),
    .we_i    ({we_right, we_left}),
    .waddr_i (point_index_i),
    .wdata_i ({point_value_i, point_value_i}),
    .raddr_i (raddr),
    .rdata_o (lr_rdata)
  );

  assign l_rdata = lr_rdata[PointW-1:0];
  assign r_rdata = lr_rdata[2*PointW-1:PointW];

  pce_ram #(.Lanes(1)) u_rinv (
    .clk_i   (clk_i),
    .we_i    (we_right),
    .waddr_i (point_value_i),
    .wdata_i (point_index_i),
    .raddr_i (raddr),
    .rdata_o (ri_rdata)
  );

  // identity extended lookup of the current step
  assign sel = table_sel(op_q, step_q);

  always_comb begin
    case (sel)
      SEL_RIGHT: begin
        tbl_data = r_rdata;
        tbl_deg  = rdeg_q;
      end
      SEL_RINV: begin
        tbl_data = ri_rdata;
        tbl_deg  = rdeg_q;
      end
      default: begin
        tbl_data = l_rdata;
        tbl_deg  = ldeg_q;
      end
    endcase
  end

  assign resolved = ({1'b0, x_q} < tbl_deg) ? tbl_data : x_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    image_q <= image_d;
    if (accept) begin
      qpt_q <= point_index_i;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    x_d     = x_q;
    valid_d = 1'b0;
    image_d = image_q;
    raddr   = point_index_i;
    unique case (state_q)
      ST_IDLE: begin
        raddr = point_index_i;
        if (accept && (cmd_i == CMD_QUERY)) begin
          state_d = ST_LOOK;
          step_d  = '0;
          x_d     = point_index_i;
        end
      end
      ST_LOOK: begin
        raddr = resolved;
        x_d   = resolved;
        if (last_step(op_q, step_q)) begin
          state_d = ST_IDLE;
          step_d  = '0;
          valid_d = 1'b1;
          image_d = resolved;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign result_valid_o  = valid_q;
  assign queried_point_o = qpt_q;
  assign image_o         = image_q;
  assign result_degree_o = (ldeg_q > rdeg_q) ? ldeg_q : rdeg_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (cmd_i == CMD_QUERY)))
    else $error("lookup started without a query transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy) && !busy))
    else $error("result strobe not at the end of a lookup");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two results in adjacent cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (step_q <= 2'd2) && (op_q == OP_CONJUGATE || step_q <= 2'd1))
    else $error("lookup step beyond the chain length");

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the permutation compose engine unit
module tb;
  import pce_pkg::*;

  localparam int SettleCycles = 8;
  localparam int PhaseItems   = 78;
  localparam int NumPhases    = 12;
  localparam int ScriptLen    = 27;

  typedef struct packed {
    point_t point;
    point_t image;
    deg_t   degree;
  } composite_t;

  typedef struct packed {
    logic       is_cfg;
    logic [1:0] code;
    logic [8:0] arg;
    point_t     val;
    logic       typed;
    point_t     img;
    deg_t       deg;
  } script_row_t;

  localparam script_row_t SCRIPT [ScriptLen] = '{
    '{1'b0, CMD_QUERY,        9'd0,   8'd0,   1'b1, 8'd0,   9'd0},
    '{1'b0, CMD_QUERY,        9'd255, 8'd0,   1'b1, 8'd255, 9'd0},
    '{1'b0, CMD_NONE,         9'd255, 8'd255, 1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_WR_LEFT,      9'd0,   8'd255, 1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_QUERY,        9'd0,   8'd255, 1'b1, 8'd0,   9'd0},
    '{1'b1, CFG_LEFT_DEGREE,  9'd511, 8'd0,   1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_QUERY,        9'd0,   8'd0,   1'b1, 8'd255, 9'd256},
    '{1'b1, CFG_LEFT_DEGREE,  9'd2,   8'd0,   1'b0, 8'd0,   9'd0},
    '{1'b1, CFG_RIGHT_DEGREE, 9'd2,   8'd0,   1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_WR_LEFT,      9'd1,   8'd0,   1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_WR_RIGHT,     9'd0,   8'd1,   1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_WR_RIGHT,     9'd1,   8'd0,   1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_QUERY,        9'd0,   8'd0,   1'b1, 8'd255, 9'd2},
    '{1'b0, CMD_QUERY,        9'd1,   8'd0,   1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_QUERY,        9'd255, 8'd0,   1'b1, 8'd255, 9'd2},
    '{1'b1, CFG_OP_MODE,      9'(OP_QUOTIENT), 8'd0, 1'b0, 8'd0, 9'd0},
    '{1'b0, CMD_QUERY,        9'd1,   8'd0,   1'b0, 8'd0,   9'd0},
    '{1'b1, CFG_OP_MODE,      9'(OP_CONJUGATE), 8'd0, 1'b0, 8'd0, 9'd0},
    '{1'b0, CMD_QUERY,        9'd0,   8'd0,   1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_WR_RIGHT,     9'd1,   8'd1,   1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_QUERY,        9'd0,   8'd0,   1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_QUERY,        9'd1,   8'd0,   1'b0, 8'd0,   9'd0},
    '{1'b1, CFG_OP_MODE,      9'(OP_UNUSED), 8'd0, 1'b0, 8'd0,  9'd0},
    '{1'b0, CMD_QUERY,        9'd1,   8'd0,   1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_WR_LEFT,      9'd255, 8'd170, 1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_WR_RIGHT,     9'd170, 8'd85,  1'b0, 8'd0,   9'd0},
    '{1'b0, CMD_QUERY,        9'd128, 8'd0,   1'b0, 8'd0,   9'd0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] cmd_i;
  point_t     point_index_i;
  point_t     point_value_i;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  deg_t       cfg_data_i;
  logic       result_valid_o;
  point_t     queried_point_o;
  point_t     image_o;
  deg_t       result_degree_o;

  permutation_compose_engine_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .point_index_i  (point_index_i),
    .point_value_i  (point_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .queried_point_o(queried_point_o),
    .image_o        (image_o),
    .result_degree_o(result_degree_o)
  );

  // shadow of the tables, indexed by table select
  point_t     perm_entry [3][MaxPoints];
  bit         perm_set   [3][MaxPoints];
  op_e        mode;
  deg_t       left_deg;
  deg_t       right_deg;
  composite_t expected_images [$];
  int         error_count;
  int         gap_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic deg_t limited(input deg_t d);
    return (d > MaxPoints) ? deg_t'(MaxPoints) : d;
  endfunction

  function automatic deg_t composite_degree();
    deg_t dl;
    deg_t dr;
    dl = limited(left_deg);
    dr = limited(right_deg);
    return (dl > dr) ? dl : dr;
  endfunction

  // walks the lookup chain; returns 0 and the first unwritten entry if one is read
  function automatic bit compose_image(input point_t k, output point_t img,
                                       output sel_e hole_tbl, output point_t hole_pos);
    sel_e   chain [3];
    int     steps;
    point_t x;
    deg_t   d;
    case (mode)
      OP_QUOTIENT: begin
        chain = '{SEL_LEFT, SEL_RINV, SEL_RINV};
        steps = 2;
      end
      OP_CONJUGATE: begin
        chain = '{SEL_RINV, SEL_LEFT, SEL_RIGHT};
        steps = 3;
      end
      default: begin
        chain = '{SEL_LEFT, SEL_RIGHT, SEL_RIGHT};
        steps = 2;
      end
    endcase
    x = k;
    hole_tbl = SEL_LEFT;
    hole_pos = '0;
    for (int i = 0; i < steps; i++) begin
      d = limited(chain[i] == SEL_LEFT ? left_deg : right_deg);
      if (x < d) begin
        if (!perm_set[chain[i]][x]) begin
          hole_tbl = chain[i];
          hole_pos = x;
          img = x;
          return 1'b0;
        end
        x = perm_entry[chain[i]][x];
      end
    end
    img = x;
    return 1'b1;
  endfunction

  task automatic send_transaction(input cmd_e c, input point_t idx, input point_t val,
                                  input bit typed, input point_t t_img, input deg_t t_deg);
    composite_t rec;
    point_t     img;
    sel_e       hole_tbl;
    point_t     hole_pos;
    @(negedge clk_i);
    start         = 1'b1;
    cmd_i         = c;
    point_index_i = idx;
    point_value_i = val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (c)
      CMD_WR_LEFT: begin
        perm_entry[SEL_LEFT][idx] = val;
        perm_set[SEL_LEFT][idx]   = 1'b1;
      end
      CMD_WR_RIGHT: begin
        perm_entry[SEL_RIGHT][idx] = val;
        perm_set[SEL_RIGHT][idx]   = 1'b1;
        perm_entry[SEL_RINV][val]  = idx;
        perm_set[SEL_RINV][val]    = 1'b1;
      end
      CMD_QUERY: begin
        void'(compose_image(idx, img, hole_tbl, hole_pos));
        rec.point  = idx;
        rec.image  = typed ? t_img : img;
        rec.degree = typed ? t_deg : composite_degree();
        expected_images.push_back(rec);
      end
      default: ;
    endcase
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      while ($urandom_range(99) < gap_pct) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_images.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input deg_t data);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    case (idx)
      CFG_OP_MODE:      mode      = op_e'(data[1:0]);
      CFG_LEFT_DEGREE:  left_deg  = data;
      CFG_RIGHT_DEGREE: right_deg = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // well-formed permutation of the first n points written into the left table, or the right table and its inverse
  task automatic load_permutation(input cmd_e c, input int n, inout int issued);
    point_t shuffled [MaxPoints];
    point_t tmp;
    int     j;
    for (int i = 0; i < n; i++) shuffled[i] = point_t'(i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = shuffled[i];
      shuffled[i] = shuffled[j];
      shuffled[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      send_transaction(c, point_t'(i), shuffled[i], 1'b0, '0, '0);
      sender_gap();
      issued++;
    end
  endtask

  always @(posedge clk_i) begin
    composite_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_images.size() == 0) begin
        $error("unexpected transaction: point %0d image %0d degree %0d",
               queried_point_o, image_o, result_degree_o);
        error_count++;
      end else begin
        want = expected_images.pop_front();
        if (queried_point_o !== want.point) begin
          $error("queried_point: expected %0d, got %0d", want.point, queried_point_o);
          error_count++;
        end
        if (image_o !== want.image) begin
          $error("image: expected %0d, got %0d", want.image, image_o);
          error_count++;
        end
        if (result_degree_o !== want.degree) begin
          $error("result_degree: expected %0d, got %0d", want.degree, result_degree_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    int     phase_pct [4];
    int     issued;
    int     r;
    deg_t   ld;
    deg_t   rd;
    deg_t   maxd;
    op_e    op;
    point_t k;
    point_t img;
    point_t hole_pos;
    sel_e   hole_tbl;

    phase_pct     = '{0, 84, 0, 23};
    error_count   = 0;
    gap_pct       = 23;
    mode          = OP_PRODUCT;
    left_deg      = '0;
    right_deg     = '0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    cmd_i         = CMD_NONE;
    point_index_i = '0;
    point_value_i = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_NONE;
    cfg_data_i    = '0;
    for (int t = 0; t < 3; t++)
      for (int i = 0; i < MaxPoints; i++) begin
        perm_entry[t][i] = '0;
        perm_set[t][i]   = 1'b0;
      end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < ScriptLen; i++) begin
      if (SCRIPT[i].is_cfg) begin
        write_register(cfg_idx_e'(SCRIPT[i].code), SCRIPT[i].arg);
      end else begin
        send_transaction(cmd_e'(SCRIPT[i].code), SCRIPT[i].arg[7:0], SCRIPT[i].val,
                         SCRIPT[i].typed, SCRIPT[i].img, SCRIPT[i].deg);
        sender_gap();
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      gap_pct = phase_pct[ph % 4];
      op = (ph < 4) ? op_e'(ph) : op_e'($urandom_range(3));
      case (ph)
        4:       begin ld = 9'd256; rd = 9'd256; end
        7:       begin ld = 9'd511; rd = deg_t'($urandom_range(257, 510)); end
        9:       begin ld = 9'd0;   rd = 9'd256; end
        default: begin
          ld = ($urandom_range(4) == 0) ? 9'd0 : deg_t'($urandom_range(1, 24));
          rd = ($urandom_range(4) == 0) ? 9'd0 : deg_t'($urandom_range(1, 24));
        end
      endcase
      if (ph == 0) write_register(CFG_NONE, deg_t'($urandom_range(511)));
      write_register(CFG_OP_MODE, deg_t'(op));
      write_register(CFG_LEFT_DEGREE, ld);
      write_register(CFG_RIGHT_DEGREE, rd);

      issued = 0;
      if ($urandom_range(9) < 7) begin
        if (limited(ld) <= 32) load_permutation(CMD_WR_LEFT, limited(ld), issued);
        if (limited(rd) <= 32) load_permutation(CMD_WR_RIGHT, limited(rd), issued);
      end
      maxd = composite_degree();

      while (issued < PhaseItems) begin
        r = $urandom_range(99);
        if (r < 10) begin
          case ($urandom_range(2))
            0:       send_transaction(CMD_WR_LEFT, point_t'($urandom_range(255)),
                                      point_t'($urandom_range(255)), 1'b0, '0, '0);
            1:       send_transaction(CMD_WR_RIGHT, point_t'($urandom_range(255)),
                                      point_t'($urandom_range(255)), 1'b0, '0, '0);
            default: send_transaction(CMD_NONE, point_t'($urandom_range(255)),
                                      point_t'($urandom_range(255)), 1'b0, '0, '0);
          endcase
        end else if (r < 25 && maxd != 0) begin
          send_transaction($urandom_range(1) ? CMD_WR_LEFT : CMD_WR_RIGHT,
                           point_t'($urandom_range(maxd - 1)),
                           point_t'($urandom_range(maxd - 1)), 1'b0, '0, '0);
        end else begin
          if (maxd != 0 && $urandom_range(9) < 8) k = point_t'($urandom_range(maxd - 1));
          else k = point_t'($urandom_range(255));
          if (compose_image(k, img, hole_tbl, hole_pos)) begin
            send_transaction(CMD_QUERY, k, point_t'($urandom_range(255)), 1'b0, '0, '0);
          end else begin
            // fill the entry the query would have read before it was written
            case (hole_tbl)
              SEL_LEFT:  send_transaction(CMD_WR_LEFT, hole_pos,
                                          point_t'($urandom_range(maxd - 1)), 1'b0, '0, '0);
              SEL_RIGHT: send_transaction(CMD_WR_RIGHT, hole_pos,
                                          point_t'($urandom_range(maxd - 1)), 1'b0, '0, '0);
              default:   send_transaction(CMD_WR_RIGHT, point_t'($urandom_range(maxd - 1)),
                                          hole_pos, 1'b0, '0, '0);
            endcase
          end
        end
        sender_gap();
        issued++;
      end
    end

    drain();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
